/* rtl/core/ppce_pkg.sv */
// shared constants and types for the palette pixel color expander
`default_nettype none

package ppce_pkg;

  // palette store geometry: three byte banks interleaved by address mod 3
  localparam int unsigned Banks    = 3;
  localparam int unsigned Rows     = 256;
  localparam int unsigned RowAw    = $clog2(Rows);
  localparam int unsigned Depth    = Banks * Rows;
  localparam int unsigned AddrW    = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LaneW    = 2;

  // divide by three through a scaled reciprocal, exact for 10-bit operands
  localparam int unsigned Recip3   = 683;
  localparam int unsigned Recip3Sh = 11;

  // cube conversion constants
  localparam int unsigned Recip6   = 171;
  localparam int unsigned Recip6Sh = 10;
  localparam int unsigned Recip36  = 57;
  localparam int unsigned Recip36Sh = 11;
  localparam int unsigned CubeStep = 42;
  localparam int unsigned CubeLvls = 6;

  typedef enum logic [1:0] {
    MODE_RGB888 = 2'd0,
    MODE_RGB444 = 2'd1,
    MODE_RGB222 = 2'd2,
    MODE_CUBE   = 2'd3
  } color_mode_e;

  typedef enum logic {
    ACT_WRITE   = 1'b0,
    ACT_CONVERT = 1'b1
  } action_e;

  // per-bank access request for one cycle
  typedef struct packed {
    logic [Banks-1:0]            we;
    logic [Banks-1:0][RowAw-1:0] row;
    logic [ByteW-1:0]            wdata;
    logic [LaneW-1:0]            lane;
  } bank_req_t;

endpackage

`default_nettype wire

/* rtl/core/ppce_bank.sv */
// one 256x8 palette bank, synchronous write and registered read
`default_nettype none

module ppce_bank
  import ppce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic             re_i,
  input  wire logic [RowAw-1:0] row_i,
  input  wire logic [ByteW-1:0] wdata_i,
  output logic      [ByteW-1:0] rdata_o
);

  logic [ByteW-1:0] mem [Rows];
  logic [ByteW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[row_i] <= wdata_i;
    end
  end

  // registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[row_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/ppce_addr.sv */
// address generation: byte address to bank and row, clearing pass and writes
`default_nettype none

module ppce_addr
  import ppce_pkg::*;
(
  input  wire logic             accept_i,
  input  wire logic             action_i,
  input  wire logic [AddrW-1:0] palette_address_i,
  input  wire logic [ByteW-1:0] palette_byte_i,
  input  wire logic [ByteW-1:0] pixel_index_i,
  input  wire color_mode_e      mode_i,
  input  wire logic             clr_busy_i,
  input  wire logic [RowAw-1:0] clr_row_i,
  output bank_req_t             req_o
);

  logic [AddrW-1:0]   a0;
  logic [2*AddrW-1:0] prod;
  logic [AddrW-2:0]   q9;
  logic [AddrW-1:0]   rem;
  logic [RowAw-1:0]   q0, q1;
  logic [LaneW-1:0]   r0, r1;
  logic               wr_ok;

  // first byte address of the access
  always_comb begin
    if (action_i == ACT_WRITE) begin
      a0 = palette_address_i;
    end else begin
      case (mode_i)
        MODE_RGB444: a0 = {1'b0, pixel_index_i, 1'b0};
        default:     a0 = {2'b00, pixel_index_i};
      endcase
    end
  end

  // divide by three and remainder
  assign prod = {{AddrW{1'b0}}, a0} * (2*AddrW)'(Recip3);
  assign q9   = prod[Recip3Sh +: (AddrW-1)];
  assign rem  = a0 - AddrW'({1'b0, q9} * AddrW'(3));
  assign r0   = rem[LaneW-1:0];
  assign q0   = q9[RowAw-1:0];

  // the following byte lives in the next bank, wrapping to the next row
  always_comb begin
    if (r0 == LaneW'(Banks-1)) begin
      r1 = '0;
      q1 = q0 + RowAw'(1);
    end else begin
      r1 = r0 + LaneW'(1);
      q1 = q0;
    end
  end

  assign wr_ok = accept_i && (action_i == ACT_WRITE) && (palette_address_i < AddrW'(Depth));

  // per-bank request
  always_comb begin
    req_o.lane  = r0;
    req_o.wdata = clr_busy_i ? '0 : palette_byte_i;
    for (int b = 0; b < Banks; b++) begin
      req_o.we[b] = clr_busy_i || (wr_ok && (r0 == LaneW'(b)));
      if (clr_busy_i) begin
        req_o.row[b] = clr_row_i;
      end else if (action_i == ACT_CONVERT && mode_i == MODE_RGB888) begin
        req_o.row[b] = pixel_index_i;
      end else if (action_i == ACT_CONVERT && mode_i == MODE_RGB444 &&
                   r1 == LaneW'(b)) begin
        req_o.row[b] = q1;
      end else begin
        req_o.row[b] = q0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/ppce_fmt.sv */
// color word formatting from the fetched palette bytes
`default_nettype none

module ppce_fmt
  import ppce_pkg::*;
(
  input  wire color_mode_e            mode_i,
  input  wire logic [LaneW-1:0]       lane_i,
  input  wire logic [Banks-1:0][ByteW-1:0] rdata_i,
  output logic      [3*ByteW-1:0]     color_o
);

  logic [ByteW-1:0]  lo, hi;
  logic [15:0]       p6;
  logic [13:0]       p36;
  logic [5:0]        q6;
  logic [2:0]        q36;
  logic [ByteW-1:0]  d_lo, d_mid;
  logic [2:0]        l_lo, l_mid, l_hi;
  logic [ByteW-1:0]  c_lo, c_mid, c_hi;

  // pick the first byte and the byte after it
  always_comb begin
    case (lane_i)
      2'd0: begin lo = rdata_i[0]; hi = rdata_i[1]; end
      2'd1: begin lo = rdata_i[1]; hi = rdata_i[2]; end
      2'd2: begin lo = rdata_i[2]; hi = rdata_i[0]; end
      default: begin lo = '0; hi = '0; end
    endcase
  end

  // cube levels: c mod 6, (c/6) mod 6, (c/36) mod 6
  assign p6    = {8'd0, lo} * 16'(Recip6);
  assign p36   = {6'd0, lo} * 14'(Recip36);
  assign q6    = p6[Recip6Sh +: 6];
  assign q36   = p36[Recip36Sh +: 3];
  assign d_lo  = lo - ({2'b00, q6} * 8'(CubeLvls));
  assign d_mid = {2'b00, q6} - ({5'd0, q36} * 8'(CubeLvls));
  assign l_lo  = d_lo[2:0];
  assign l_mid = d_mid[2:0];
  assign l_hi  = (q36 >= 3'(CubeLvls)) ? (q36 - 3'(CubeLvls)) : q36;
  assign c_lo  = {5'd0, l_lo}  * 8'(CubeStep);
  assign c_mid = {5'd0, l_mid} * 8'(CubeStep);
  assign c_hi  = {5'd0, l_hi}  * 8'(CubeStep);

  // field placement per mode
  always_comb begin
    case (mode_i)
      MODE_RGB888: color_o = {rdata_i[2], rdata_i[1], rdata_i[0]};
      MODE_RGB444: color_o = {lo[3:0], 4'h0, lo[7:4], 4'h0, hi[3:0], 4'h0};
      MODE_RGB222: color_o = {lo[1:0], 6'd0, lo[3:2], 6'd0, lo[5:4], 6'd0};
      MODE_CUBE:   color_o = {c_lo, c_mid, c_hi};
      default:     color_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/palette_pixel_color_expander.sv */
// Palette pixel color expander: converts 8-bit pixel indices to 24-bit color words through
// a 768-byte palette held as three 256x8 banks interleaved by byte address mod 3, so every
// mode fetches all its bytes in one read per bank. Throughput is one item per cycle unless
// the output stalls; a convert result goes from the bank read registers, loaded when the
// item is taken, to the output register, waiting in the read stage on a stall.
// A palette write gives no result. After reset a clearing pass zeroes all 256 rows, one row
// of all three banks per cycle, during which in_ready_o is low; configuration writes are
// taken at any time and must only be issued while the block is idle.
`default_nettype none

module palette_pixel_color_expander
  import ppce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [1:0]       color_mode_i,
  // input items
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             action_i,
  input  wire logic [AddrW-1:0] palette_address_i,
  input  wire logic [ByteW-1:0] palette_byte_i,
  input  wire logic [ByteW-1:0] pixel_index_i,
  // results
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [3*ByteW-1:0]    color_word_o
);

  color_mode_e                    color_mode_q;
  logic                           clr_busy_q;
  logic [RowAw-1:0]               clr_row_q;
  logic                           s1_valid_q, s1_valid_d;
  logic [LaneW-1:0]               lane_q;
  logic                           out_valid_q, out_valid_d;
  logic [3*ByteW-1:0]             color_q, color_d;
  logic                           in_accept, out_load, s1_adv;
  bank_req_t                      req;
  logic [Banks-1:0][ByteW-1:0]    rdata;

  assign cfg_ready_o = 1'b1;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= MODE_RGB888;
    end else if (cfg_valid_i && cfg_ready_o) begin
      color_mode_q <= color_mode_e'(color_mode_i);
    end
  end

  // clearing pass over the bank rows after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_row_q  <= '0;
    end else if (clr_busy_q) begin
      clr_row_q <= clr_row_q + RowAw'(1);
      if (clr_row_q == RowAw'(Rows-1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline flow control
  assign out_load   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign s1_adv     = !s1_valid_q || out_load;
  assign in_ready_o = s1_adv && !clr_busy_q;
  assign in_accept  = in_valid_i && in_ready_o;

  ppce_addr u_addr (
    .accept_i          (in_accept),
    .action_i          (action_i),
    .palette_address_i (palette_address_i),
    .palette_byte_i    (palette_byte_i),
    .pixel_index_i     (pixel_index_i),
    .mode_i            (color_mode_q),
    .clr_busy_i        (clr_busy_q),
    .clr_row_i         (clr_row_q),
    .req_o             (req)
  );

  // palette banks
  for (genvar b = 0; b < Banks; b++) begin : g_bank
    ppce_bank u_bank (
      .clk_i   (clk_i),
      .we_i    (req.we[b]),
      .re_i    (s1_adv),
      .row_i   (req.row[b]),
      .wdata_i (req.wdata),
      .rdata_o (rdata[b])
    );
  end

  // read stage control
  assign s1_valid_d = s1_adv ? (in_accept && (action_i == ACT_CONVERT)) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lane_q <= req.lane;
    end
  end

  ppce_fmt u_fmt (
    .mode_i  (color_mode_q),
    .lane_i  (lane_q),
    .rdata_i (rdata),
    .color_o (color_d)
  );

  // output register
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      color_q <= color_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign color_word_o = color_q;

`ifndef SYNTHESIS
  // no input transfer during the clearing pass
  a_clr_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("input transfer while palette is being cleared");

  // a convert transfer occupies the read stage next cycle
  a_convert_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == ACT_CONVERT) |=> s1_valid_q)
    else $error("convert item lost at read stage");

  // a write transfer never creates a result
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && action_i == ACT_WRITE) |=> !s1_valid_q)
    else $error("palette write produced a result");

  // a fetched result waits in the read stage until the output register takes it
  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_load) |=> (s1_valid_q && $stable(lane_q)))
    else $error("stalled read stage dropped its item");
`endif

endmodule

`default_nettype wire
